### rtl/core/aes128_block_encrypt_macros.svh
// Assertion macros for the AES-128 block encryption core.
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/core/aes_pkg.sv
// Package with AES-128 types, the S-box and round helper functions.
`default_nettype none
package aes_pkg;
  localparam int unsigned Rounds = 10;
  localparam logic KeyHighIndex = 1'b0;
  localparam logic KeyLowIndex = 1'b1;
  typedef logic [127:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] c;
    c = 8'h01;
    for (int i = 1; i < 10; i++) begin
      if (4'(i) < r) c = xtime(c);
    end
    return c;
  endfunction

  // Byte n of a block sits in bits 127-8n down to 120-8n.
  function automatic block_t sub_shift(input block_t s);
    block_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      o[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  function automatic block_t round_key_step(input block_t k, input logic [3:0] r);
    logic [31:0] t;
    block_t o;
    t = {sbox(k[23:16]), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])} ^ {rcon(r), 24'h0};
    o[127:96] = k[127:96] ^ t;
    o[95:64] = k[95:64] ^ o[127:96];
    o[63:32] = k[63:32] ^ o[95:64];
    o[31:0] = k[31:0] ^ o[63:32];
    return o;
  endfunction
endpackage
`default_nettype wire

### rtl/core/aes_key_sched.sv
// Round key schedule expanded from the key registers into held round keys.
`default_nettype none
module aes_key_sched (
  input  wire logic               clk,
  input  wire logic [127:0]       key,
  output aes_pkg::block_t         rkey [11]
);
  // Entry i holds the key of round i + 1; each advances one stage per cycle with the data.
  aes_pkg::block_t k [10];
  always_ff @(posedge clk) begin
    k[0] <= aes_pkg::round_key_step(key, 4'd1);
    for (int i = 1; i < 10; i++) begin
      k[i] <= aes_pkg::round_key_step(k[i - 1], 4'(i + 1));
    end
  end
  always_comb begin
    rkey[0] = key;
    for (int i = 0; i < 10; i++) begin
      rkey[i + 1] = k[i];
    end
  end
endmodule
`default_nettype wire

### rtl/core/aes_round.sv
// One registered AES round stage: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
`default_nettype none
module aes_round #(
  parameter bit Final = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire aes_pkg::block_t in_state,
  input  wire aes_pkg::block_t rkey,
  output logic                 out_valid,
  output aes_pkg::block_t      out_state
);
  aes_pkg::block_t s;
  always_comb begin
    s = aes_pkg::sub_shift(in_state);
    if (!Final) s = aes_pkg::mix_columns(s);
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
    out_state <= s ^ rkey;
  end
endmodule
`default_nettype wire

### rtl/core/aes128_block_encrypt.sv
// AES-128 ECB encryption core, one round per pipeline stage.
// Throughput one per cycle; done is raised once a word has passed the input register and ten round stages.
// The input stage does the initial AddRoundKey, then ten round stages follow.
// Round key r is registered in step with the data of round r, so a new key applies to the next word.
// Synchronous reset clears the valid pipeline and key registers; results cannot stall.
`default_nettype none
`include "aes128_block_encrypt_macros.svh"
module aes128_block_encrypt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] plain_high,
  input  wire logic [63:0] plain_low,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic             done,
  output logic [63:0]      cipher_high,
  output logic [63:0]      cipher_low
);
  logic [63:0] key_high, key_low;
  aes_pkg::block_t rkey [11];
  aes_pkg::block_t st [11];
  logic vld [11];
  aes_pkg::block_t st_in;
  logic vld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes_pkg::KeyHighIndex: key_high <= cfg_data;
        aes_pkg::KeyLowIndex: key_low <= cfg_data;
      endcase
    end
  end

  aes_key_sched u_ks (.clk(clk), .key({key_high, key_low}), .rkey(rkey));

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) vld_in <= 1'b0;
    else vld_in <= start;
    st_in <= {plain_high, plain_low} ^ rkey[0];
  end

  assign vld[0] = vld_in;
  assign st[0] = st_in;

  for (genvar r = 1; r <= aes_pkg::Rounds; r++) begin : g_rnd
    aes_round #(.Final(r == aes_pkg::Rounds)) u_rnd (
      .clk(clk), .rst(rst), .in_valid(vld[r - 1]), .in_state(st[r - 1]),
      .rkey(rkey[r]), .out_valid(vld[r]), .out_state(st[r])
    );
  end

  assign done = vld[10];
  assign cipher_high = st[10][127:64];
  assign cipher_low = st[10][63:0];

  `AES_ASSERT_NEXT(a_start_enters, clk, rst, start, vld[0], "Accepted word did not enter the pipeline.")
  `AES_ASSERT_NEXT(a_done_follows, clk, rst, vld[9], done, "Round nine word did not reach the output.")
  `AES_ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy, "Core reported busy.")
endmodule
`default_nettype wire
